### hw/rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants for the binary trie multiset.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 4096;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LVL_W      = $clog2(KEY_BITS);
  localparam int NEED_W     = $clog2(KEY_BITS + 1);
  // rank residue: start value plus one signed count subtracted per level
  localparam int RANK_W     = 33 + $clog2(KEY_BITS + 1);

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_FIND = 3'd1,
    OP_KTH  = 3'd2,
    OP_SUM  = 3'd3,
    OP_XOR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // what the read data in flight belongs to
  typedef enum logic [2:0] {
    P_NODE,  // record of the node just moved to
    P_K0,    // left child record, k-th query
    P_S0,    // left child record, sum query
    P_X1,    // opposite child record, xor query
    P_CHK,   // pool check between the two add passes
    P_A      // record of the node being updated, add second pass
  } phase_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [31:0]       count;
    logic [63:0]       sum;
  } node_t;

endpackage

### hw/rtl/bts_if.sv
// ----------------------------------------------------------------------------
// bts_req_if / bts_rsp_if
// Valid/ready channels for operations and their results.
// ----------------------------------------------------------------------------
interface bts_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [30:0]        key;
  logic signed [31:0] delta;
  logic [30:0]        rank;

  modport source(output valid, op, key, delta, rank, input ready);
  modport sink(input valid, op, key, delta, rank, output ready);
endinterface

interface bts_rsp_if;
  logic               valid;
  logic               ready;
  logic               present;
  logic [30:0]        value;
  logic signed [63:0] total;
  logic               pool_full;

  modport source(output valid, present, value, total, pool_full, input ready);
  modport sink(input valid, present, value, total, pool_full, output ready);
endinterface

### hw/rtl/binary_trie_multiset.sv
// ----------------------------------------------------------------------------
// binary_trie_multiset
// Multiset of keys held as a binary trie in one node memory.
// ----------------------------------------------------------------------------
// After reset the node memory is cleared one entry per cycle, all NODE_COUNT
// (4096) entries, with req.ready low. One operation is worked at a time by a
// sequencer around the node memory (one read, one write per cycle, registered
// read data). A query visits one node per key bit: membership and the
// plain descent take one read per level, the k-th, sum and max-xor queries
// up to two reads per level. An add walks the path twice (count the nodes
// still missing and check the free pool, then update and allocate). Unused
// op codes skip the walk and go straight to the result. A finished result
// waits in the output register while the next operation is already taken.
module binary_trie_multiset (
  input  logic      clk,
  input  logic      rst,
  bts_req_if.sink   req,
  bts_rsp_if.source rsp
);

  localparam int NW = bts_pkg::NODE_W;

  bts_pkg::node_t node_mem [bts_pkg::NODE_COUNT];
  bts_pkg::node_t rdata;

  bts_pkg::state_t state, state_next;
  bts_pkg::phase_t phase, phase_next;

  logic [NW-1:0]                  clr_idx;
  logic [2:0]                     op_r;
  logic [30:0]                    key_r;
  logic signed [31:0]             delta_r;
  logic signed [bts_pkg::RANK_W-1:0] rk, rk_next;
  logic signed [63:0]             prod;
  logic [NW-1:0]                  cur_l, cur_l_next, cur_r, cur_r_next, alt, alt_next;
  logic [bts_pkg::LVL_W-1:0]      lvl, lvl_next;
  logic                           leaf, leaf_next;
  logic [bts_pkg::NEED_W-1:0]     need, need_next;
  logic [bts_pkg::FREE_W-1:0]     next_free, next_free_next;
  logic                           pres, pres_next, full, full_next;
  logic [30:0]                    ans, ans_next;
  logic [63:0]                    acc, acc_next;

  logic                           fin, op_ok, accept, out_load;
  logic                           rd_en, wr_en;
  logic [NW-1:0]                  rd_addr, wr_addr;
  bts_pkg::node_t                 wr_data;

  assign accept   = (state == bts_pkg::S_IDLE) && req.valid;
  assign out_load = (state == bts_pkg::S_DONE) && (!rsp.valid || rsp.ready);
  assign op_ok    = (req.op == bts_pkg::OP_ADD) || (req.op == bts_pkg::OP_FIND) ||
                    (req.op == bts_pkg::OP_KTH) || (req.op == bts_pkg::OP_SUM) ||
                    (req.op == bts_pkg::OP_XOR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bts_pkg::S_CLEAR: if (clr_idx == NW'(bts_pkg::NODE_COUNT - 1)) state_next = bts_pkg::S_IDLE;
      bts_pkg::S_IDLE:  if (accept) state_next = op_ok ? bts_pkg::S_WALK : bts_pkg::S_DONE;
      bts_pkg::S_WALK:  if (fin) state_next = bts_pkg::S_DONE;
      bts_pkg::S_DONE:  if (out_load) state_next = bts_pkg::S_IDLE;
      default:          state_next = bts_pkg::S_CLEAR;
    endcase
  end

  assign req.ready = (state == bts_pkg::S_IDLE);

  // walk datapath
  always_comb begin
    logic          b;
    logic          mv;
    logic [NW-1:0] mv_c;
    logic [NW-1:0] c;
    bts_pkg::node_t nrec;
    b              = key_r[lvl];
    mv             = 1'b0;
    mv_c           = '0;
    c              = '0;
    nrec           = rdata;
    fin            = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    phase_next     = phase;
    rk_next        = rk;
    cur_l_next     = cur_l;
    cur_r_next     = cur_r;
    alt_next       = alt;
    lvl_next       = lvl;
    leaf_next      = leaf;
    need_next      = need;
    next_free_next = next_free;
    pres_next      = pres;
    full_next      = full;
    ans_next       = ans;
    acc_next       = acc;

    if (state == bts_pkg::S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else if (accept) begin
      rd_en      = 1'b1;
      phase_next = bts_pkg::P_NODE;
      lvl_next   = bts_pkg::LVL_W'(bts_pkg::KEY_BITS - 1);
      leaf_next  = 1'b0;
      rk_next    = bts_pkg::RANK_W'($signed({1'b0, req.rank}));
      need_next  = '0;
      pres_next  = 1'b0;
      full_next  = 1'b0;
      ans_next   = '0;
      acc_next   = '0;
    end else if (state == bts_pkg::S_WALK) begin
      case (phase)
        bts_pkg::P_NODE: begin
          cur_l_next = rdata.left;
          cur_r_next = rdata.right;
          c = b ? rdata.right : rdata.left;
          case (op_r)
            bts_pkg::OP_ADD: begin
              if (leaf) begin
                phase_next = bts_pkg::P_CHK;
              end else if (c == '0) begin
                need_next  = bts_pkg::NEED_W'(lvl) + 1'b1;
                phase_next = bts_pkg::P_CHK;
              end else begin
                mv = 1'b1; mv_c = c;
              end
            end
            bts_pkg::OP_FIND: begin
              if (leaf) begin
                pres_next = $signed(rdata.count) > 0;
                fin = 1'b1;
              end else if (c == '0) begin
                fin = 1'b1;
              end else begin
                mv = 1'b1; mv_c = c;
              end
            end
            bts_pkg::OP_KTH: begin
              if (leaf) begin
                fin = 1'b1;
              end else if (rdata.left != '0) begin
                rd_en = 1'b1; rd_addr = rdata.left; phase_next = bts_pkg::P_K0;
              end else if (rdata.right == '0) begin
                fin = 1'b1;
              end else begin
                ans_next[lvl] = 1'b1;
                mv = 1'b1; mv_c = rdata.right;
              end
            end
            bts_pkg::OP_SUM: begin
              if (leaf) begin
                acc_next = acc + rdata.sum;
                fin = 1'b1;
              end else if (b && rdata.left != '0) begin
                rd_en = 1'b1; rd_addr = rdata.left; phase_next = bts_pkg::P_S0;
              end else if (c == '0) begin
                fin = 1'b1;
              end else begin
                mv = 1'b1; mv_c = c;
              end
            end
            bts_pkg::OP_XOR: begin
              alt_next = b ? rdata.left : rdata.right;
              if (leaf) begin
                fin = 1'b1;
              end else if (alt_next != '0) begin
                rd_en = 1'b1; rd_addr = alt_next; phase_next = bts_pkg::P_X1;
              end else if (c == '0) begin
                fin = 1'b1;
              end else begin
                mv = 1'b1; mv_c = c;
              end
            end
            default: fin = 1'b1;
          endcase
        end
        bts_pkg::P_K0: begin
          if (rk <= bts_pkg::RANK_W'($signed(rdata.count))) begin
            mv = 1'b1; mv_c = cur_l;
          end else begin
            rk_next = rk - bts_pkg::RANK_W'($signed(rdata.count));
            if (cur_r == '0) begin
              fin = 1'b1;
            end else begin
              ans_next[lvl] = 1'b1;
              mv = 1'b1; mv_c = cur_r;
            end
          end
        end
        bts_pkg::P_S0: begin
          acc_next = acc + rdata.sum;
          if (cur_r == '0) begin
            fin = 1'b1;
          end else begin
            mv = 1'b1; mv_c = cur_r;
          end
        end
        bts_pkg::P_X1: begin
          c = b ? cur_r : cur_l;
          if ($signed(rdata.count) > 0) begin
            ans_next[lvl] = 1'b1;
            mv = 1'b1; mv_c = alt;
          end else if (c == '0) begin
            fin = 1'b1;
          end else begin
            mv = 1'b1; mv_c = c;
          end
        end
        bts_pkg::P_CHK: begin
          if (next_free > bts_pkg::FREE_W'(bts_pkg::NODE_COUNT) ||
              (bts_pkg::FREE_W + 1)'(need) >
              (bts_pkg::FREE_W + 1)'(bts_pkg::NODE_COUNT) - (bts_pkg::FREE_W + 1)'(next_free)) begin
            full_next = 1'b1;
            fin = 1'b1;
          end else begin
            rd_en      = 1'b1;
            phase_next = bts_pkg::P_A;
            lvl_next   = bts_pkg::LVL_W'(bts_pkg::KEY_BITS - 1);
            leaf_next  = 1'b0;
          end
        end
        bts_pkg::P_A: begin
          nrec.count = rdata.count + delta_r;
          nrec.sum   = rdata.sum + prod;
          wr_en   = 1'b1;
          wr_addr = cur_l;
          if (leaf) begin
            fin = 1'b1;
          end else begin
            c = b ? rdata.right : rdata.left;
            if (c == '0) begin
              c = next_free[NW-1:0];
              next_free_next = next_free + 1'b1;
              if (b) nrec.right = c;
              else   nrec.left  = c;
            end
            mv = 1'b1; mv_c = c;
          end
          wr_data = nrec;
        end
        default: fin = 1'b1;
      endcase

      if (mv) begin
        rd_en   = 1'b1;
        rd_addr = mv_c;
        if (phase != bts_pkg::P_A) phase_next = bts_pkg::P_NODE;
        if (lvl == '0) leaf_next = 1'b1;
        else           lvl_next  = lvl - 1'b1;
        // second pass keeps the address of the node being updated
        if (phase == bts_pkg::P_A) cur_l_next = mv_c;
      end
      if (phase == bts_pkg::P_CHK && !fin) cur_l_next = '0;
    end
  end

  // node memory
  always_ff @(posedge clk) begin
    if (wr_en) node_mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bts_pkg::S_CLEAR;
      clr_idx   <= '0;
      next_free <= bts_pkg::FREE_W'(1);
      rsp.valid <= 1'b0;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      if (state == bts_pkg::S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (out_load) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    rk    <= rk_next;
    cur_l <= cur_l_next;
    cur_r <= cur_r_next;
    alt   <= alt_next;
    lvl   <= lvl_next;
    leaf  <= leaf_next;
    need  <= need_next;
    pres  <= pres_next;
    full  <= full_next;
    ans   <= ans_next;
    acc   <= acc_next;
    prod  <= 64'($signed({33'b0, key_r}) * 64'(delta_r));
    if (accept) begin
      op_r    <= req.op;
      key_r   <= req.key & 31'((64'd1 << bts_pkg::KEY_BITS) - 64'd1);
      delta_r <= req.delta;
    end
    if (out_load) begin
      rsp.present   <= pres;
      rsp.value     <= ans;
      rsp.total     <= $signed(acc);
      rsp.pool_full <= full;
    end
  end

endmodule

### hw/rtl/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks on the result channel of the trie multiset.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_present,
  input logic [30:0] rsp_value,
  input logic [63:0] rsp_total,
  input logic        rsp_pool_full
);

  // a stalled beat stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total) && $stable(rsp_value))
    else $error("result beat dropped or changed while stalled");

  // each op fills one field only
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_present && rsp_pool_full))
    else $error("membership and pool-full both set");

  a_total_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_total != 64'd0 |-> !rsp_present && !rsp_pool_full && rsp_value == 31'd0)
    else $error("sum result mixed with other fields");

  a_value_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_value != 31'd0 |-> !rsp_present && !rsp_pool_full)
    else $error("value result mixed with flags");

endmodule

bind binary_trie_multiset bts_checker u_bts_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_present  (rsp.present),
  .rsp_value    (rsp.value),
  .rsp_total    (rsp.total),
  .rsp_pool_full(rsp.pool_full)
);
